>>> sv/key_debounce_press_classifier_macros.svh
// ----------------------------------------------------------------------------
// Key debounce press classifier assertion macros
// Shared concurrent assertion forms, clocked on aclk, muted in reset.
// ----------------------------------------------------------------------------
`ifndef KEY_DEBOUNCE_PRESS_CLASSIFIER_MACROS_SVH
`define KEY_DEBOUNCE_PRESS_CLASSIFIER_MACROS_SVH

// same-cycle implication
`define KDPC_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define KDPC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/kdpc_pkg.sv
// ----------------------------------------------------------------------------
// kdpc_pkg
// Types and constants of the key debounce press classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package kdpc_pkg;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned LIMIT_W = 16;
    localparam int unsigned INDEX_W = 2;
    localparam int unsigned EVENT_W = 3;

    localparam logic [LIMIT_W-1:0] DEBOUNCE_RST    = 16'd20;
    localparam logic [LIMIT_W-1:0] SHORT_LIMIT_RST = 16'd500;
    localparam logic [LIMIT_W-1:0] LONG_LIMIT_RST  = 16'd1000;

    typedef enum logic [INDEX_W-1:0] {
        REG_DEBOUNCE    = 2'd0,
        REG_SHORT_LIMIT = 2'd1,
        REG_LONG_LIMIT  = 2'd2
    } reg_index_t;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE         = 3'd0,
        EV_PRESS        = 3'd1,
        EV_SHORT        = 3'd2,
        EV_LONG         = 3'd3,
        EV_LONG_RELEASE = 3'd4
    } event_t;

    typedef struct packed {
        logic [LIMIT_W-1:0] debounce_ms;
        logic [LIMIT_W-1:0] short_limit_ms;
        logic [LIMIT_W-1:0] long_limit_ms;
    } cfg_t;

endpackage

`default_nettype wire

>>> sv/key_debounce_press_classifier.sv
// An accepted poll beat passes the input register, then the output register, to its event beat on the m_ side.
// Throughput: one poll per cycle while the m_ side does not stall; one event beat for every poll beat.
// The input register may refill in the cycle its beat moves to the output register.
// Reset: synchronous, active low; key reads released, timestamps 0, limits 20/500/1000.
// ----------------------------------------------------------------------------
// key_debounce_press_classifier
// Key debouncer with press, short press, long press and long release events.
// ----------------------------------------------------------------------------
`default_nettype none
`include "key_debounce_press_classifier_macros.svh"

module key_debounce_press_classifier (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [kdpc_pkg::INDEX_W-1:0] cfg_index,
    input  wire logic [kdpc_pkg::LIMIT_W-1:0] cfg_data,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic                        s_key_down,
    input  wire logic [kdpc_pkg::TIME_W-1:0]  s_now_ms,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [kdpc_pkg::EVENT_W-1:0]      m_event_res
);
    import kdpc_pkg::*;

    cfg_t              cfg;
    event_t            core_event;

    logic              in_valid_reg;
    logic              in_key_reg;
    logic [TIME_W-1:0] in_now_reg;
    logic              out_valid_reg;
    event_t            out_event_reg;
    logic              advance;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;

    kdpc_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    kdpc_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .fire      (advance),
        .key_down  (in_key_reg),
        .now_ms    (in_now_reg),
        .event_res (core_event)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_key_reg <= s_key_down;
            in_now_reg <= s_now_ms;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_event_reg <= core_event;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_event_res = out_event_reg;

    `KDPC_ASSERT_IMPL(a_stall_cause, !s_ready, out_valid_reg && !m_ready, "stall without cause")
    `KDPC_ASSERT_NEXT(a_advance_fills, advance, out_valid_reg, "output not loaded on advance")
    `KDPC_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_event_res), "beat dropped")

endmodule

`default_nettype wire

>>> sv/kdpc_cfg_regs.sv
// ----------------------------------------------------------------------------
// kdpc_cfg_regs
// Configuration register file: debounce time and short and long limits.
// ----------------------------------------------------------------------------
`default_nettype none

module kdpc_cfg_regs (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        wr_en,
    input  wire logic [kdpc_pkg::INDEX_W-1:0] wr_index,
    input  wire logic [kdpc_pkg::LIMIT_W-1:0] wr_data,
    output kdpc_pkg::cfg_t                   cfg
);
    import kdpc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (wr_index)
                REG_DEBOUNCE:    cfg_next.debounce_ms    = wr_data;
                REG_SHORT_LIMIT: cfg_next.short_limit_ms = wr_data;
                REG_LONG_LIMIT:  cfg_next.long_limit_ms  = wr_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ms    <= DEBOUNCE_RST;
            cfg_reg.short_limit_ms <= SHORT_LIMIT_RST;
            cfg_reg.long_limit_ms  <= LONG_LIMIT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> sv/kdpc_core.sv
// ----------------------------------------------------------------------------
// kdpc_core
// Debounce state and press classification, one poll per cycle while fire is high.
// ----------------------------------------------------------------------------
`default_nettype none
`include "key_debounce_press_classifier_macros.svh"

module kdpc_core (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire kdpc_pkg::cfg_t             cfg,
    input  wire logic                       fire,
    input  wire logic                       key_down,
    input  wire logic [kdpc_pkg::TIME_W-1:0] now_ms,
    output kdpc_pkg::event_t                event_res
);
    import kdpc_pkg::*;

    logic              raw_reg;
    logic              raw_next;
    logic              stable_reg;
    logic              stable_next;
    logic              long_reg;
    logic              long_next;
    logic [TIME_W-1:0] press_time_reg;
    logic [TIME_W-1:0] press_time_next;
    logic [TIME_W-1:0] change_time_reg;
    logic [TIME_W-1:0] change_time_next;

    logic [TIME_W-1:0] since_change;
    logic [TIME_W-1:0] held;
    logic              raw_changed;
    logic              settled;
    logic              held_long;
    logic              held_short;
    event_t            ev;

    assign since_change = now_ms - change_time_reg;
    assign held         = now_ms - press_time_reg;
    assign raw_changed  = key_down != raw_reg;
    assign settled      = since_change >= {{(TIME_W-LIMIT_W){1'b0}}, cfg.debounce_ms};
    assign held_long    = held >= {{(TIME_W-LIMIT_W){1'b0}}, cfg.long_limit_ms};
    assign held_short   = held <= {{(TIME_W-LIMIT_W){1'b0}}, cfg.short_limit_ms};

    always_comb begin
        raw_next         = raw_reg;
        stable_next      = stable_reg;
        long_next        = long_reg;
        press_time_next  = press_time_reg;
        change_time_next = change_time_reg;
        ev               = EV_NONE;
        if (raw_changed) begin
            raw_next         = key_down;
            change_time_next = now_ms;
        end else if (key_down != stable_reg) begin
            if (settled) begin
                stable_next = key_down;
                long_next   = 1'b0;
                if (key_down) begin
                    press_time_next = now_ms;
                    ev              = EV_PRESS;
                end else if (long_reg || held_long) begin
                    ev = EV_LONG_RELEASE;
                end else if (held_short) begin
                    ev = EV_SHORT;
                end
            end
        end else if (stable_reg && !long_reg && held_long) begin
            long_next = 1'b1;
            ev        = EV_LONG;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raw_reg         <= 1'b0;
            stable_reg      <= 1'b0;
            long_reg        <= 1'b0;
            press_time_reg  <= '0;
            change_time_reg <= '0;
        end else if (fire) begin
            raw_reg         <= raw_next;
            stable_reg      <= stable_next;
            long_reg        <= long_next;
            press_time_reg  <= press_time_next;
            change_time_reg <= change_time_next;
        end
    end

    assign event_res = ev;

    `KDPC_ASSERT_IMPL(a_change_silent, fire && raw_changed, ev == EV_NONE, "event on raw change")
    `KDPC_ASSERT_NEXT(a_long_sets_flag, fire && ev == EV_LONG, long_reg, "long flag not set")
    `KDPC_ASSERT_IMPL(a_flag_while_held, long_reg, stable_reg, "long flag while released")

endmodule

`default_nettype wire

>>> bench/key_debounce_press_classifier_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_debounce_press_classifier_tb
// Drives key polls with timestamps through the classifier under several
// register settings, zero and full-scale limits among them, with random
// idle bursts on poll and event channels. Each event beat is checked against
// its typed directed row or an in-bench model of debouncer and press timers.
// ----------------------------------------------------------------------------
module key_debounce_press_classifier_tb;
    import kdpc_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned PHASE_POLLS = 210;

    typedef struct {
        logic               key;
        logic [TIME_W-1:0]  ts;
        bit                 typed;
        event_t             ev;
    } poll_row_t;

    logic                aclk;
    logic                aresetn;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [INDEX_W-1:0]  cfg_index;
    logic [LIMIT_W-1:0]  cfg_data;
    logic                s_valid;
    logic                s_ready;
    logic                s_key_down;
    logic [TIME_W-1:0]   s_now_ms;
    logic                m_valid;
    logic                m_ready;
    logic [EVENT_W-1:0]  m_event_res;

    // model state
    cfg_t                live_cfg;
    logic                key_raw;
    logic                key_stable;
    logic                long_seen;
    logic [TIME_W-1:0]   press_ts;
    logic [TIME_W-1:0]   change_ts;

    event_t              pending_events[$];
    bit                  calm;
    int unsigned         cycles;
    int unsigned         mismatches;
    int unsigned         polls_sent;
    int unsigned         settings_used;
    int unsigned         seen[5];
    logic [TIME_W-1:0]   ts_now;
    logic                run_level;

    poll_row_t directed_rows[25] = '{
        '{1'b0, 32'd0,         1'b1, EV_NONE},
        '{1'b1, 32'd100,       1'b1, EV_NONE},
        '{1'b1, 32'd110,       1'b1, EV_NONE},
        '{1'b1, 32'd120,       1'b1, EV_PRESS},
        '{1'b1, 32'd1119,      1'b0, EV_NONE},
        '{1'b1, 32'd1120,      1'b1, EV_LONG},
        '{1'b1, 32'd1200,      1'b0, EV_NONE},
        '{1'b0, 32'd1300,      1'b1, EV_NONE},
        '{1'b0, 32'd1320,      1'b1, EV_LONG_RELEASE},
        '{1'b1, 32'd2000,      1'b0, EV_NONE},
        '{1'b1, 32'd2020,      1'b1, EV_PRESS},
        '{1'b0, 32'd2300,      1'b0, EV_NONE},
        '{1'b0, 32'd2520,      1'b1, EV_SHORT},
        '{1'b1, 32'd3000,      1'b0, EV_NONE},
        '{1'b1, 32'd3020,      1'b1, EV_PRESS},
        '{1'b0, 32'd3600,      1'b0, EV_NONE},
        '{1'b0, 32'd3621,      1'b0, EV_NONE},
        '{1'b1, 32'd4000,      1'b0, EV_NONE},
        '{1'b0, 32'd4005,      1'b0, EV_NONE},
        '{1'b0, 32'd4030,      1'b0, EV_NONE},
        '{1'b1, 32'hFFFF_FFF0, 1'b0, EV_NONE},
        '{1'b1, 32'h0000_0004, 1'b0, EV_NONE},
        '{1'b1, 32'hFFFF_FFFF, 1'b0, EV_NONE},
        '{1'b0, 32'h0000_0010, 1'b0, EV_NONE},
        '{1'b0, 32'h0000_0030, 1'b0, EV_NONE}
    };

    key_debounce_press_classifier dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_key_down  (s_key_down),
        .s_now_ms    (s_now_ms),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_event_res (m_event_res)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic event_t predict_event(input logic key, input logic [TIME_W-1:0] ts);
        logic [TIME_W-1:0] since;
        logic              long_hold;
        if (key != key_raw) begin
            key_raw   = key;
            change_ts = ts;
            return EV_NONE;
        end
        if (key != key_stable) begin
            since = ts - change_ts;
            if (since < {16'd0, live_cfg.debounce_ms})
                return EV_NONE;
            key_stable = key;
            if (key) begin
                press_ts  = ts;
                long_seen = 1'b0;
                return EV_PRESS;
            end
            since     = ts - press_ts;
            long_hold = long_seen || (since >= {16'd0, live_cfg.long_limit_ms});
            long_seen = 1'b0;
            if (long_hold)
                return EV_LONG_RELEASE;
            if (since <= {16'd0, live_cfg.short_limit_ms})
                return EV_SHORT;
            return EV_NONE;
        end
        since = ts - press_ts;
        if (key_stable && !long_seen && since >= {16'd0, live_cfg.long_limit_ms}) begin
            long_seen = 1'b1;
            return EV_LONG;
        end
        return EV_NONE;
    endfunction

    task automatic send_poll(input logic key, input logic [TIME_W-1:0] ts,
                             input bit typed, input event_t typed_ev);
        event_t ev;
        if (!calm && $urandom_range(3, 0) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(8, 1)) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_key_down <= key;
        s_now_ms   <= ts;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        ev = predict_event(key, ts);
        pending_events.push_back(typed ? typed_ev : ev);
        polls_sent++;
    endtask

    // drain the pipeline, then load all registers plus the spare index
    task automatic apply_settings(input cfg_t c);
        logic [INDEX_W-1:0] idx;
        logic [LIMIT_W-1:0] val;
        logic [INDEX_W-1:0] first;
        s_valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        first = INDEX_W'($urandom_range(3, 0));
        for (int k = 0; k < 4; k++) begin
            idx = first + INDEX_W'(k);
            case (idx)
                REG_DEBOUNCE:    val = c.debounce_ms;
                REG_SHORT_LIMIT: val = c.short_limit_ms;
                REG_LONG_LIMIT:  val = c.long_limit_ms;
                default:         val = LIMIT_W'($urandom_range(65535, 0));
            endcase
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= val;
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            case (idx)
                REG_DEBOUNCE:    live_cfg.debounce_ms    = val;
                REG_SHORT_LIMIT: live_cfg.short_limit_ms = val;
                REG_LONG_LIMIT:  live_cfg.long_limit_ms  = val;
                default:         ;
            endcase
        end
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // runs of held levels with random spacing, some glitches and noise
    task automatic run_random(input int unsigned count);
        int unsigned done;
        int unsigned span;
        int unsigned n;
        bit          noisy;
        logic        k;
        done = 0;
        span = live_cfg.long_limit_ms;
        if (live_cfg.debounce_ms > span)
            span = live_cfg.debounce_ms;
        if (live_cfg.short_limit_ms > span)
            span = live_cfg.short_limit_ms;
        span = span / 3 + 4;
        while (done < count) begin
            run_level = !run_level;
            n     = ($urandom_range(5, 0) == 0) ? 1 : $urandom_range(14, 2);
            noisy = ($urandom_range(9, 0) == 0);
            for (int i = 0; i < n && done < count; i++) begin
                if ($urandom_range(49, 0) == 0)
                    ts_now = $urandom();
                else
                    ts_now = ts_now + $urandom_range(span, 0);
                k = noisy ? 1'($urandom_range(1, 0)) : run_level;
                send_poll(k, ts_now, 1'b0, EV_NONE);
                done++;
            end
        end
    endtask

    // event side: check beats, stall in bursts
    initial begin
        int unsigned stall_left;
        event_t      want;
        stall_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (m_event_res < 5)
                    seen[m_event_res]++;
                if (pending_events.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected event beat: got %0d", m_event_res);
                    mismatches++;
                end else begin
                    want = pending_events.pop_front();
                    if (m_event_res !== want) begin
                        if (mismatches < 10)
                            $display("event mismatch: expected %0d, got %0d",
                                     want, m_event_res);
                        mismatches++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (!calm && $urandom_range(5, 0) == 0) begin
                stall_left = $urandom_range(8, 1) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("key_debounce_press_classifier_tb: errors");
        $finish;
    end

    initial begin
        cfg_t plan[$];
        cfg_t c;
        aresetn    <= 1'b0;
        cfg_valid  <= 1'b0;
        cfg_index  <= REG_DEBOUNCE;
        cfg_data   <= '0;
        s_valid    <= 1'b0;
        s_key_down <= 1'b0;
        s_now_ms   <= '0;
        calm          = 1'b0;
        mismatches    = 0;
        polls_sent    = 0;
        settings_used = 0;
        live_cfg   = '{DEBOUNCE_RST, SHORT_LIMIT_RST, LONG_LIMIT_RST};
        key_raw    = 1'b0;
        key_stable = 1'b0;
        long_seen  = 1'b0;
        press_ts   = '0;
        change_ts  = '0;
        ts_now     = 32'h0000_0030;
        run_level  = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            send_poll(directed_rows[i].key, directed_rows[i].ts,
                      directed_rows[i].typed, directed_rows[i].ev);

        plan.push_back('{16'd0, 16'd0, 16'd0});
        plan.push_back('{16'hFFFF, 16'hFFFF, 16'hFFFF});
        plan.push_back('{16'd0, 16'hFFFF, 16'd0});
        plan.push_back('{16'hFFFF, 16'd0, 16'hFFFF});
        c.debounce_ms    = 16'($urandom_range(40, 0));
        c.short_limit_ms = 16'($urandom_range(700, 0));
        c.long_limit_ms  = 16'($urandom_range(1500, 0));
        plan.push_back(c);
        c.debounce_ms    = 16'($urandom_range(10, 0));
        c.long_limit_ms  = 16'($urandom_range(300, 0));
        c.short_limit_ms = 16'($urandom_range(800, c.long_limit_ms));
        plan.push_back(c);
        c.debounce_ms    = 16'($urandom_range(65535, 0));
        c.short_limit_ms = 16'($urandom_range(65535, 0));
        c.long_limit_ms  = 16'($urandom_range(65535, 0));
        plan.push_back(c);
        plan.push_back('{DEBOUNCE_RST, SHORT_LIMIT_RST, LONG_LIMIT_RST});

        foreach (plan[p]) begin
            apply_settings(plan[p]);
            if (p == plan.size() - 1)
                calm = 1'b1;
            run_random(PHASE_POLLS);
        end

        s_valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        mismatches += pending_events.size();

        $display("%0d polls under %0d register settings (zero and full-scale limits included)",
                 polls_sent, settings_used);
        $display("events: none %0d, press %0d, short %0d, long %0d, long release %0d",
                 seen[0], seen[1], seen[2], seen[3], seen[4]);
        if (mismatches == 0)
            $display("key_debounce_press_classifier_tb: clean");
        else
            $display("key_debounce_press_classifier_tb: errors");
        $finish;
    end

endmodule
